// ===== hdl/sam_pkg.sv =====
// ----------------------------------------------------------------------------
// sam_pkg
// Shared types and constants of the sensor average and range map block.
// ----------------------------------------------------------------------------
package sam_pkg;

  localparam int SampleBitsDef = 12;
  localparam int FracBitsDef   = 8;
  localparam int ValueW        = 16;
  localparam int MapW          = ValueW + 1;
  localparam int ProdW         = 2 * MapW;
  localparam int MagW          = 2 * ValueW;
  localparam int CountW        = 8;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 16;

  localparam logic [CountW-1:0] AvgCountRst = CountW'(1);
  localparam logic [ValueW-1:0] InMinRst    = ValueW'(0);
  localparam logic [ValueW-1:0] InMaxRst    = ValueW'(4095);
  localparam logic [ValueW-1:0] OutMinRst   = ValueW'(0);
  localparam logic [ValueW-1:0] OutMaxRst   = ValueW'(4095);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_AVG_ENABLE = 3'd0,
    CFG_AVG_COUNT  = 3'd1,
    CFG_MAP_ENABLE = 3'd2,
    CFG_IN_MIN     = 3'd3,
    CFG_IN_MAX     = 3'd4,
    CFG_OUT_MIN    = 3'd5,
    CFG_OUT_MAX    = 3'd6
  } sam_cfg_idx_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic avg_sum;
    logic avg_sub;
    logic avg_go;
    logic avg_upd;
    logic map_mul;
    logic map_go;
    logic map_upd;
    logic map_zero;
    logic out_load;
  } sam_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic avg_en;
    logic map_en;
    logic span_zero;
    logic div_done;
  } sam_sts_t;

  // Dividend width of the shared divider: wide enough for the running sum
  // and for the magnitude of the mapping product.
  function automatic int div_width(input int sum_bits);
    return (sum_bits > MagW) ? sum_bits : MagW;
  endfunction

endpackage

// ===== hdl/sam_div.sv =====
// ----------------------------------------------------------------------------
// sam_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sam_div import sam_pkg::*; #(
  parameter int DVD_W = 32,
  parameter int DVS_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CntW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  always_comb begin
    trial  = {rem_q, quo_q[DVD_W-1]};
    diff   = trial - {1'b0, dvs_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CntW'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hdl/sam_datapath.sv =====
// ----------------------------------------------------------------------------
// sam_datapath
// Configuration registers, averaging state, mapping arithmetic and output
// register of the sensor average and range map block.
// ----------------------------------------------------------------------------
module sam_datapath import sam_pkg::*; #(
  parameter int SAMPLE_BITS = SampleBitsDef,
  parameter int FRAC_BITS   = FracBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  sam_cmd_t               cmd_i,
  output sam_sts_t               sts_o,
  output logic [ValueW-1:0]      value_o,
  output logic                   span_error_o
);

  localparam int AvgBits = SAMPLE_BITS + FRAC_BITS;
  localparam int SumBits = AvgBits + 8;
  localparam int DivW    = div_width(SumBits);

  // configuration
  logic              avg_en_q;
  logic [CountW-1:0] avg_count_q;
  logic              map_en_q;
  logic [ValueW-1:0] in_min_q, in_max_q, out_min_q, out_max_q;

  // averaging state
  logic [SumBits-1:0] running_sum_q;
  logic [AvgBits-1:0] average_out_q;

  // working registers
  logic [ValueW-1:0]       v_q;
  logic                    err_q;
  logic [SumBits:0]        acc_q;
  logic signed [ProdW-1:0] prod_q;
  logic                    q_neg_q;
  logic [ValueW-1:0]       value_q;
  logic                    span_error_q;

  logic [SumBits:0]        acc_d;
  logic [SumBits:0]        diff;
  logic [SumBits-1:0]      sum_sat;
  logic [CountW-1:0]       count_eff;
  logic [DivW-1:0]         quotient;
  logic                    div_done;
  logic [AvgBits-1:0]      avg_new;
  logic signed [MapW-1:0]  dx, dy, dn;
  logic [ProdW-1:0]        prod_neg;
  logic [MagW-1:0]         prod_mag;
  logic [MapW-1:0]         dn_neg;
  logic [ValueW-1:0]       dn_mag;
  logic                    div_start;
  logic [DivW-1:0]         div_dividend;
  logic [ValueW-1:0]       div_divisor;
  logic [ValueW-1:0]       q16;
  logic [ValueW-1:0]       map_res;

  always_comb begin
    acc_d = (SumBits+1)'(running_sum_q)
          + (SumBits+1)'(AvgBits'(v_q[SAMPLE_BITS-1:0]) << FRAC_BITS);
    diff  = (acc_q >= (SumBits+1)'(average_out_q))
          ? acc_q - (SumBits+1)'(average_out_q) : '0;
    sum_sat   = diff[SumBits] ? {SumBits{1'b1}} : diff[SumBits-1:0];
    count_eff = (avg_count_q == '0) ? CountW'(1) : avg_count_q;
    avg_new   = (|quotient[DivW-1:AvgBits]) ? {AvgBits{1'b1}}
                                            : quotient[AvgBits-1:0];
  end

  // mapping terms, signed over one extra bit
  always_comb begin
    dx       = $signed({1'b0, v_q})      - $signed({1'b0, in_min_q});
    dy       = $signed({1'b0, out_max_q}) - $signed({1'b0, out_min_q});
    dn       = $signed({1'b0, in_max_q})  - $signed({1'b0, in_min_q});
    prod_neg = -prod_q;
    prod_mag = prod_q[ProdW-1] ? prod_neg[MagW-1:0] : prod_q[MagW-1:0];
    dn_neg   = -dn;
    dn_mag   = dn[MapW-1] ? dn_neg[ValueW-1:0] : dn[ValueW-1:0];
    q16      = quotient[ValueW-1:0];
    map_res  = (q_neg_q ? (ValueW'(0) - q16) : q16) + out_min_q;
  end

  always_comb begin
    div_start    = cmd_i.avg_go | cmd_i.map_go;
    div_dividend = cmd_i.map_go ? DivW'(prod_mag) : DivW'(running_sum_q);
    div_divisor  = cmd_i.map_go ? dn_mag : ValueW'(count_eff);
  end

  sam_div #(
    .DVD_W (DivW),
    .DVS_W (ValueW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_en_q      <= 1'b0;
      avg_count_q   <= AvgCountRst;
      map_en_q      <= 1'b0;
      in_min_q      <= InMinRst;
      in_max_q      <= InMaxRst;
      out_min_q     <= OutMinRst;
      out_max_q     <= OutMaxRst;
      running_sum_q <= '0;
      average_out_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_AVG_ENABLE: avg_en_q    <= cfg_data_i[0];
          CFG_AVG_COUNT:  avg_count_q <= cfg_data_i[CountW-1:0];
          CFG_MAP_ENABLE: map_en_q    <= cfg_data_i[0];
          CFG_IN_MIN:     in_min_q    <= cfg_data_i[ValueW-1:0];
          CFG_IN_MAX:     in_max_q    <= cfg_data_i[ValueW-1:0];
          CFG_OUT_MIN:    out_min_q   <= cfg_data_i[ValueW-1:0];
          CFG_OUT_MAX:    out_max_q   <= cfg_data_i[ValueW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.avg_sub) begin
        running_sum_q <= sum_sat;
      end
      if (cmd_i.avg_upd) begin
        average_out_q <= avg_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      v_q   <= ValueW'(sample_i);
      err_q <= 1'b0;
    end
    if (cmd_i.avg_sum) begin
      acc_q <= acc_d;
    end
    if (cmd_i.avg_upd) begin
      v_q <= ValueW'(avg_new >> FRAC_BITS);
    end
    if (cmd_i.map_mul) begin
      prod_q <= dx * dy;
    end
    if (cmd_i.map_go) begin
      q_neg_q <= prod_q[ProdW-1] ^ dn[MapW-1];
    end
    if (cmd_i.map_upd) begin
      v_q <= map_res;
    end
    if (cmd_i.map_zero) begin
      v_q   <= out_min_q;
      err_q <= 1'b1;
    end
    if (cmd_i.out_load) begin
      value_q      <= v_q;
      span_error_q <= err_q;
    end
  end

  assign sts_o.avg_en    = avg_en_q;
  assign sts_o.map_en    = map_en_q;
  assign sts_o.span_zero = (in_max_q == in_min_q);
  assign sts_o.div_done  = div_done;

  assign value_o      = value_q;
  assign span_error_o = span_error_q;

endmodule

// ===== hdl/sam_ctrl.sv =====
// ----------------------------------------------------------------------------
// sam_ctrl
// Sequencer of the sensor average and range map block: steps one sample
// through averaging and mapping and owns the output handshake.
// ----------------------------------------------------------------------------
module sam_ctrl import sam_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  sam_sts_t sts_i,
  output sam_cmd_t cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_A_SUM  = 10'b00_0000_0010,
    ST_A_SUB  = 10'b00_0000_0100,
    ST_A_GO   = 10'b00_0000_1000,
    ST_A_WAIT = 10'b00_0001_0000,
    ST_M_MUL  = 10'b00_0010_0000,
    ST_M_GO   = 10'b00_0100_0000,
    ST_M_WAIT = 10'b00_1000_0000,
    ST_M_ZERO = 10'b01_0000_0000,
    ST_FIN    = 10'b10_0000_0000
  } sam_state_e;

  sam_state_e state_q, state_d;
  sam_state_e map_next;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    if (!sts_i.map_en) begin
      map_next = ST_FIN;
    end else if (sts_i.span_zero) begin
      map_next = ST_M_ZERO;
    end else begin
      map_next = ST_M_MUL;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = sts_i.avg_en ? ST_A_SUM : map_next;
        end
      end
      ST_A_SUM: begin
        cmd_o.avg_sum = 1'b1;
        state_d = ST_A_SUB;
      end
      ST_A_SUB: begin
        cmd_o.avg_sub = 1'b1;
        state_d = ST_A_GO;
      end
      ST_A_GO: begin
        cmd_o.avg_go = 1'b1;
        state_d = ST_A_WAIT;
      end
      ST_A_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.avg_upd = 1'b1;
          state_d = map_next;
        end
      end
      ST_M_MUL: begin
        cmd_o.map_mul = 1'b1;
        state_d = ST_M_GO;
      end
      ST_M_GO: begin
        cmd_o.map_go = 1'b1;
        state_d = ST_M_WAIT;
      end
      ST_M_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.map_upd = 1'b1;
          state_d = ST_FIN;
        end
      end
      ST_M_ZERO: begin
        cmd_o.map_zero = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        // hold the finished result until the output register has room
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/sensor_average_and_range_map.sv =====
// ----------------------------------------------------------------------------
// sensor_average_and_range_map
// Exponential 1/N average of converter samples in fixed point, followed by
// a linear rescale of the value with truncating division.
// ----------------------------------------------------------------------------
//  Channel  Signals                                   Direction
//  input    in_valid_i, in_ready_o, sample_i           sink
//  output   out_valid_o, out_ready_i, value_o,
//           span_error_o                              source
//  config   cfg_valid_i, cfg_ready_o, cfg_index_i,
//           cfg_data_i                                sink
//
//  One sample is in work at a time; the single serial divider works at
//  one quotient bit per cycle, DIV_W = max(SAMPLE_BITS + FRAC_BITS + 8,
//  32) bits per division.
//  A finished result sits in the output register while the next sample is
//  taken; a stalled output holds the next result back in the last step.
//  Reset is asynchronous and restores the register defaults and a zero
//  running sum and average. Config transfers are always taken.
// ----------------------------------------------------------------------------
module sensor_average_and_range_map import sam_pkg::*; #(
  parameter int SAMPLE_BITS = SampleBitsDef,
  parameter int FRAC_BITS   = FracBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ValueW-1:0]      value_o,
  output logic                   span_error_o
);

  sam_cmd_t cmd;
  sam_sts_t sts;

  assign cfg_ready_o = 1'b1;

  sam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sam_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .sample_i     (sample_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .value_o      (value_o),
    .span_error_o (span_error_o)
  );

endmodule

// ===== hdl/sam_checker.sv =====
// ----------------------------------------------------------------------------
// sam_checker
// Port-level checks of the sensor average and range map block.
// ----------------------------------------------------------------------------
module sam_checker import sam_pkg::*; #(
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   cfg_ready_o,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic [SAMPLE_BITS-1:0] sample_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [ValueW-1:0]      value_o,
  input logic                   span_error_o
);

  logic       in_xfer, out_xfer;
  logic [1:0] pending_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // count samples taken whose results are not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending_q <= pending_q + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o)
                                    && $stable(span_error_o))
    else $error("result changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> pending_q != 2'd0)
    else $error("result without a sample");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 2'd2 |-> !in_ready_o)
    else $error("sample taken with result waiting and one in work");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(sample_i))
    else $error("sample changed while waiting");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind sensor_average_and_range_map sam_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_sam_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_ready_o  (cfg_ready_o),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .sample_i     (sample_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .value_o      (value_o),
  .span_error_o (span_error_o)
);
